### rtl/iptpe_pkg.sv
`default_nettype none
package iptpe_pkg;

  // parse phases, one-hot
  typedef enum logic [4:0] {
    PH_IP_HDR  = 5'b00001,
    PH_IP_OPT  = 5'b00010,
    PH_TCP_HDR = 5'b00100,
    PH_TCP_OPT = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  localparam int unsigned IDX_W = 6;  // longest phase is 40 option bytes

  localparam logic [IDX_W:0] HDR_BYTES = 7'd20;
  localparam logic [3:0] MIN_WORDS = 4'd5;
  localparam logic [3:0] WORD_MASK = 4'h0f;

  // byte positions inside the fixed headers
  localparam logic [IDX_W-1:0] POS_IHL     = 6'd0;
  localparam logic [IDX_W-1:0] POS_LEN_HI  = 6'd2;
  localparam logic [IDX_W-1:0] POS_LEN_LO  = 6'd3;
  localparam logic [IDX_W-1:0] POS_SRC_LO  = 6'd12;
  localparam logic [IDX_W-1:0] POS_SRC_HI  = 6'd15;
  localparam logic [IDX_W-1:0] POS_DST_LO  = 6'd16;
  localparam logic [IDX_W-1:0] POS_DST_HI  = 6'd19;
  localparam logic [IDX_W-1:0] POS_TCP_OFF = 6'd12;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_packet;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_item_t;

  // header length field with short values raised to the minimum
  function automatic logic [3:0] eff_words(input logic [3:0] w);
    logic [3:0] v;
    v = w & WORD_MASK;
    return (v < MIN_WORDS) ? MIN_WORDS : v;
  endfunction

  // option bytes that follow a 20 byte fixed header
  function automatic logic [IDX_W-1:0] opt_bytes(input logic [3:0] w);
    logic [3:0] extra;
    extra = eff_words(w) - MIN_WORDS;
    return {extra, 2'b00};
  endfunction

endpackage
`default_nettype wire

### rtl/iptpe_front.sv
`default_nettype none
module iptpe_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic [7:0]         data_byte,
  output iptpe_pkg::q_item_t      push
);

  iptpe_pkg::phase_t phase, phase_next;
  logic [iptpe_pkg::IDX_W-1:0] idx, idx_next;
  logic [3:0]  header_words, header_words_next;
  logic [15:0] total_length, total_length_next;
  logic [3:0]  tcp_words, tcp_words_next;
  logic [31:0] packet_source, packet_source_next;
  logic [31:0] packet_dest, packet_dest_next;
  logic [31:0] flow_source, flow_source_next;
  logic [31:0] flow_dest, flow_dest_next;
  logic        flow_learned, flow_learned_next;
  logic [15:0] payload_left, payload_left_next;

  logic [iptpe_pkg::IDX_W:0]   idx_inc;
  logic [iptpe_pkg::IDX_W-1:0] hidx;
  logic [iptpe_pkg::IDX_W:0]   hdr_len;
  logic [15:0] hdr_len_w;
  logic [15:0] fin_left;
  logic        match;
  logic        last;

  assign idx_inc = {1'b0, idx} + 7'd1;
  assign hdr_len = {1'b0, iptpe_pkg::eff_words(header_words), 2'b00}
                 + {1'b0, iptpe_pkg::eff_words(tcp_words), 2'b00};
  assign hdr_len_w = {9'd0, hdr_len};
  assign fin_left = (total_length > hdr_len_w) ? (total_length - hdr_len_w) : 16'd0;
  assign match = (packet_source == flow_source) && (packet_dest == flow_dest);
  assign last = (payload_left <= 16'd1);
  // an unknown phase code restarts the IP header at its first byte
  assign hidx = (phase == iptpe_pkg::PH_IP_HDR) ? idx : '0;

  always_comb begin
    phase_next         = phase;
    idx_next           = idx;
    header_words_next  = header_words;
    total_length_next  = total_length;
    tcp_words_next     = tcp_words;
    packet_source_next = packet_source;
    packet_dest_next   = packet_dest;
    flow_source_next   = flow_source;
    flow_dest_next     = flow_dest;
    flow_learned_next  = flow_learned;
    payload_left_next  = payload_left;
    push.valid         = 1'b0;
    push.entry.payload_byte   = data_byte;
    push.entry.last_of_packet = last;

    unique case (phase)
      iptpe_pkg::PH_IP_OPT: begin
        if (idx_inc >= {1'b0, iptpe_pkg::opt_bytes(header_words)}) begin
          idx_next   = '0;
          phase_next = iptpe_pkg::PH_TCP_HDR;
        end else begin
          idx_next = idx_inc[iptpe_pkg::IDX_W-1:0];
        end
      end

      iptpe_pkg::PH_TCP_HDR: begin
        if (idx == iptpe_pkg::POS_TCP_OFF) begin
          tcp_words_next = data_byte[7:4];
        end
        if (idx_inc >= iptpe_pkg::HDR_BYTES) begin
          payload_left_next = fin_left;
          idx_next          = '0;
          if (iptpe_pkg::eff_words(tcp_words) > iptpe_pkg::MIN_WORDS) begin
            phase_next = iptpe_pkg::PH_TCP_OPT;
          end else if (fin_left != 16'd0) begin
            phase_next = iptpe_pkg::PH_PAYLOAD;
          end else begin
            phase_next = iptpe_pkg::PH_IP_HDR;
          end
        end else begin
          idx_next = idx_inc[iptpe_pkg::IDX_W-1:0];
        end
      end

      iptpe_pkg::PH_TCP_OPT: begin
        if (idx_inc >= {1'b0, iptpe_pkg::opt_bytes(tcp_words)}) begin
          idx_next   = '0;
          phase_next = (payload_left != 16'd0) ? iptpe_pkg::PH_PAYLOAD
                                               : iptpe_pkg::PH_IP_HDR;
        end else begin
          idx_next = idx_inc[iptpe_pkg::IDX_W-1:0];
        end
      end

      iptpe_pkg::PH_PAYLOAD: begin
        payload_left_next = last ? 16'd0 : (payload_left - 16'd1);
        if (last) begin
          idx_next   = '0;
          phase_next = iptpe_pkg::PH_IP_HDR;
        end
        push.valid = match;
      end

      default: begin
        if (hidx == iptpe_pkg::POS_IHL) begin
          header_words_next = data_byte[3:0];
        end else if (hidx == iptpe_pkg::POS_LEN_HI) begin
          total_length_next = {data_byte, total_length[7:0]};
        end else if (hidx == iptpe_pkg::POS_LEN_LO) begin
          total_length_next = {total_length[15:8], data_byte};
        end else if (hidx >= iptpe_pkg::POS_SRC_LO && hidx <= iptpe_pkg::POS_SRC_HI) begin
          packet_source_next = {packet_source[23:0], data_byte};
        end else if (hidx >= iptpe_pkg::POS_DST_LO && hidx <= iptpe_pkg::POS_DST_HI) begin
          packet_dest_next = {packet_dest[23:0], data_byte};
        end

        if (({1'b0, hidx} + 7'd1) >= iptpe_pkg::HDR_BYTES) begin
          // first packet fixes the flow, addresses swapped
          if (!flow_learned) begin
            flow_source_next  = packet_dest_next;
            flow_dest_next    = packet_source_next;
            flow_learned_next = 1'b1;
          end
          idx_next   = '0;
          phase_next = (iptpe_pkg::eff_words(header_words_next) > iptpe_pkg::MIN_WORDS)
                       ? iptpe_pkg::PH_IP_OPT : iptpe_pkg::PH_TCP_HDR;
        end else begin
          idx_next   = hidx + 6'd1;
          phase_next = iptpe_pkg::PH_IP_HDR;
        end
      end
    endcase

    if (!in_fire) begin
      push.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= iptpe_pkg::PH_IP_HDR;
      idx           <= '0;
      header_words  <= '0;
      total_length  <= '0;
      tcp_words     <= '0;
      packet_source <= '0;
      packet_dest   <= '0;
      flow_source   <= '0;
      flow_dest     <= '0;
      flow_learned  <= 1'b0;
      payload_left  <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      idx           <= idx_next;
      header_words  <= header_words_next;
      total_length  <= total_length_next;
      tcp_words     <= tcp_words_next;
      packet_source <= packet_source_next;
      packet_dest   <= packet_dest_next;
      flow_source   <= flow_source_next;
      flow_dest     <= flow_dest_next;
      flow_learned  <= flow_learned_next;
      payload_left  <= payload_left_next;
    end
  end

endmodule
`default_nettype wire

### rtl/iptpe_queue.sv
`default_nettype none
module iptpe_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire iptpe_pkg::q_item_t push,
  input  wire logic               pop,
  output iptpe_pkg::q_item_t      head,
  output logic                    full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  iptpe_pkg::q_entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full       = (count == DEPTH[AW:0]);
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/iptpe_back.sv
`default_nettype none
module iptpe_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire iptpe_pkg::q_item_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              payload_byte,
  output logic                    last_of_packet
);

  // refill the output register whenever it is empty or being taken
  assign pop = head.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      payload_byte   <= head.entry.payload_byte;
      last_of_packet <= head.entry.last_of_packet;
    end
  end

endmodule
`default_nettype wire

### rtl/ipv4_tcp_payload_extract.sv
`default_nettype none
// Pulls TCP payload out of a raw stream of back-to-back IPv4+TCP packets, one
// byte per item, and passes on only the bytes of packets in the same direction
// as the first packet seen with its addresses swapped (server to client); the
// final payload byte of each such packet carries last_of_packet. Header length
// fields below 5 words count as 5 and a total length shorter than both headers
// gives an empty payload. One byte is taken every cycle while the queue has
// room: the header parser updates its counters and address registers as each
// byte is accepted, and a QUEUE_DEPTH entry queue plus an output register let
// the parser run on while the downstream side stalls. in_ready drops only
// when that queue is full. A payload byte is queued at its accepting edge and
// moves on to out_valid once the output register is empty or being taken.
module ipv4_tcp_payload_extract #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      payload_byte,
  output logic            last_of_packet
);

  iptpe_pkg::q_item_t push;
  iptpe_pkg::q_item_t head;
  logic q_full;
  logic pop;
  logic in_fire;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  iptpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .push      (push)
  );

  iptpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  iptpe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .last_of_packet (last_of_packet)
  );

  // parser only emits for an accepted byte, and never into a full queue
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (in_valid && in_ready && !q_full))
    else $error("payload pushed without an accepted item");

  // the output register is only loaded from a non-empty queue
  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

  // nothing appears at the output straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
